>>> rtl/sprite_frame_sequencer_core_assert.svh
// Assertion macros for the sprite frame sequencer.
// Expects signals clk and arst_n in the scope of use.
`ifndef SPRITE_FRAME_SEQUENCER_CORE_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication
`define SFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sfs_pkg.sv
// Shared constants for the sprite frame sequencer.
// No dependencies.
`timescale 1ns / 1ps

package sfs_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int FRAC_BITS       = 8;

	localparam int POS_W    = 32;
	localparam int DUR_W    = 16;
	localparam int RES_W    = 16;
	localparam int ENTRY_W  = DUR_W + RES_W;
	localparam int FRAME_W  = 8;
	localparam int ACC_W    = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// function codes
	localparam logic [1:0] FN_TICK    = 2'd0;
	localparam logic [1:0] FN_WRITE   = 2'd1;
	localparam logic [1:0] FN_RESTART = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SUPPRESS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BINDING  = 3'd6;

	localparam logic [15:0] SPEED_RST = 16'd256;

endpackage

>>> rtl/sfs_channels.sv
// Valid/ready channel interfaces for the sprite frame sequencer.
// Depends on nothing but plain logic types.
`timescale 1ns / 1ps

interface sfs_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic        hold;
	logic [7:0]  entry_index;
	logic [15:0] entry_duration;
	logic [15:0] entry_resource;
	logic [23:0] start_position;

	modport source (output valid, func, hold, entry_index, entry_duration,
		entry_resource, start_position, input ready);
	modport sink (input valid, func, hold, entry_index, entry_duration,
		entry_resource, start_position, output ready);
endinterface

interface sfs_rsp_if;
	logic               valid;
	logic               ready;
	logic [7:0]         frame_index;
	logic [15:0]        frame_resource;
	logic               frame_changed;
	logic               invalidate;
	logic               done_res;
	logic signed [31:0] position;

	modport source (output valid, frame_index, frame_resource, frame_changed,
		invalidate, done_res, position, input ready);
	modport sink (input valid, frame_index, frame_resource, frame_changed,
		invalidate, done_res, position, output ready);
endinterface

>>> rtl/sfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package use.
`timescale 1ns / 1ps

module sfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/sprite_frame_sequencer_core.sv
// Sprite frame sequencer top level: config registers, sequencer, shared adder.
// Depends on sfs_pkg, sfs_channels (sfs_req_if, sfs_rsp_if), sfs_ram.
`timescale 1ns / 1ps

// Sprite animation frame sequencer. Each request transfer is a tick, a frame
// table write, a restart or a no-op (unused code), and yields exactly one
// response transfer with the current frame index, its resource word,
// change/invalidate flags, the done flag and the signed 24.8 position. Items
// are handled one at a time: a table write, restart, no-op, held tick or tick
// after done skips the walk; a running tick adds the speed, wraps or clamps,
// then walks the frame table, up to frame_count entries, until the position
// falls inside one (none for a negative position or an empty sequence).
// The walk is bounded by the frame table's single read port, one duration per
// cycle. All position math (speed add, loop wrap or clamp, duration
// accumulate) runs through one shared 32-bit adder. A finished response sits
// in an output register, so the next request is taken while it waits. The
// frame table has no reset; reading an entry never written gives an
// undefined resource or duration.
module sprite_frame_sequencer_core #(
	parameter int TABLE_DEPTH = sfs_pkg::TABLE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sfs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	sfs_req_if.sink                          req,
	sfs_rsp_if.source                        rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int SW = (AW > 9) ? AW : 9;   // address sum width before wrap
	localparam int FB = sfs_pkg::FRAC_BITS;
	localparam int PW = sfs_pkg::POS_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ADD    = 3'd1;
	localparam logic [2:0] S_FIX    = 3'd2;
	localparam logic [2:0] S_WSTART = 3'd3;
	localparam logic [2:0] S_WALK   = 3'd4;
	localparam logic [2:0] S_RES    = 3'd5;
	localparam logic [2:0] S_OUT    = 3'd6;

	// configuration
	logic [15:0] speed_q;
	logic        loop_q;
	logic [7:0]  first_q;
	logic [7:0]  count_q;
	logic [15:0] total_q;
	logic        suppress_q;
	logic        binding_q;

	// sequencer and state
	logic [2:0]           state_q;
	logic [PW-1:0]        pos_q;
	logic                 done_q;
	logic [7:0]           cur_q;
	logic [7:0]           i_q;
	logic [sfs_pkg::ACC_W-1:0] acc_q;
	logic                 chg_q;
	logic                 inv_q;

	// output register
	logic                 ov_q;
	logic [7:0]           o_idx_q;
	logic [15:0]          o_res_q;
	logic                 o_chg_q;
	logic                 o_inv_q;
	logic                 o_done_q;
	logic [PW-1:0]        o_pos_q;

	// shared adder
	logic [PW-1:0] add_a, add_b, add_y;
	logic          add_ci;

	logic [PW-1:0]    span;
	logic [PW-FB-1:0] elapsed;
	logic             pos_neg, pos_over;
	logic [sfs_pkg::ACC_W-1:0] acc_new;
	logic             in_xfer, load_out;
	logic             fin;
	logic [7:0]       fin_idx;
	logic [7:0]       rd_off;
	logic [SW-1:0]    rd_sum, wr_sum;
	logic [AW-1:0]    rd_addr, wr_addr;
	logic [sfs_pkg::ENTRY_W-1:0] rdata;
	logic [8:0]       i_next;

	assign in_xfer  = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign load_out = (state_q == S_OUT) && (!ov_q || rsp.ready);

	assign span     = {8'b0, total_q, {FB{1'b0}}};
	assign elapsed  = pos_q[PW-1:FB];
	assign pos_neg  = pos_q[PW-1];
	assign pos_over = !pos_neg && (elapsed >= (PW-FB)'(total_q));
	assign acc_new  = add_y[sfs_pkg::ACC_W-1:0];
	assign i_next   = {1'b0, i_q} + 9'd1;

	// operand select for the one adder
	always_comb begin
		add_a  = pos_q;
		add_b  = {{16{speed_q[15]}}, speed_q};
		add_ci = 1'b0;
		case (state_q)
			S_FIX: begin
				if (pos_neg) begin
					add_b = span;
				end else if (loop_q) begin
					add_b  = ~span;
					add_ci = 1'b1;
				end else begin
					// clamp: (total - 1), shifted into place afterwards
					add_a = {16'b0, total_q};
					add_b = {PW{1'b1}};
				end
			end
			S_WALK: begin
				add_a = {8'b0, acc_q};
				add_b = {16'b0, rdata[sfs_pkg::DUR_W-1:0]};
			end
			default: ;
		endcase
	end

	assign add_y = add_a + add_b + {{(PW-1){1'b0}}, add_ci};

	// walk termination
	always_comb begin
		fin     = 1'b0;
		fin_idx = 8'd0;
		case (state_q)
			S_WSTART: begin
				fin = pos_neg || (count_q == 8'd0);
			end
			S_WALK: begin
				if ((PW-FB)'(acc_new) > elapsed) begin
					fin     = 1'b1;
					fin_idx = i_q;
				end else if (i_next == {1'b0, count_q}) begin
					fin     = 1'b1;
					fin_idx = count_q;
				end
			end
			default: ;
		endcase
	end

	// table addressing wraps modulo the depth
	always_comb begin
		case (state_q)
			S_WSTART: rd_off = 8'd0;
			S_WALK:   rd_off = i_next[7:0];
			default:  rd_off = cur_q;
		endcase
	end

	assign rd_sum  = SW'(first_q) + SW'(rd_off);
	assign rd_addr = rd_sum[AW-1:0];
	assign wr_sum  = SW'(req.entry_index);
	assign wr_addr = wr_sum[AW-1:0];

	sfs_ram #(
		.WIDTH(sfs_pkg::ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (in_xfer && (req.func == sfs_pkg::FN_WRITE)),
		.waddr (wr_addr),
		.wdata ({req.entry_resource, req.entry_duration}),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q    <= sfs_pkg::SPEED_RST;
			loop_q     <= 1'b0;
			first_q    <= 8'd0;
			count_q    <= 8'd0;
			total_q    <= 16'd0;
			suppress_q <= 1'b0;
			binding_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				sfs_pkg::REG_SPEED:    speed_q    <= cfg_wdata;
				sfs_pkg::REG_LOOP:     loop_q     <= cfg_wdata[0];
				sfs_pkg::REG_FIRST:    first_q    <= cfg_wdata[7:0];
				sfs_pkg::REG_COUNT:    count_q    <= cfg_wdata[7:0];
				sfs_pkg::REG_TOTAL:    total_q    <= cfg_wdata;
				sfs_pkg::REG_SUPPRESS: suppress_q <= cfg_wdata[0];
				sfs_pkg::REG_BINDING:  binding_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q   <= '0;
			done_q  <= 1'b0;
			cur_q   <= 8'd0;
			i_q     <= 8'd0;
			acc_q   <= '0;
			chg_q   <= 1'b0;
			inv_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						chg_q   <= 1'b0;
						inv_q   <= 1'b0;
						state_q <= S_RES;
						case (req.func)
							sfs_pkg::FN_TICK: begin
								if (!req.hold && !done_q) begin
									state_q <= S_ADD;
								end
							end
							sfs_pkg::FN_RESTART: begin
								pos_q  <= PW'(req.start_position);
								done_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_ADD: begin
					pos_q   <= add_y;
					state_q <= S_FIX;
				end
				S_FIX: begin
					if (pos_neg) begin
						if (loop_q) begin
							pos_q <= add_y;
						end else begin
							pos_q  <= '0;
							done_q <= 1'b1;
						end
					end else if (pos_over) begin
						if (loop_q) begin
							pos_q <= add_y;
						end else begin
							pos_q  <= {add_y[PW-FB-1:0], {FB{1'b0}}};
							done_q <= 1'b1;
						end
					end
					state_q <= S_WSTART;
				end
				S_WSTART: begin
					acc_q <= '0;
					i_q   <= 8'd0;
					if (!fin) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					acc_q <= acc_new;
					i_q   <= i_next[7:0];
				end
				S_RES: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (fin) begin
				state_q <= S_RES;
				if (fin_idx != cur_q) begin
					cur_q <= fin_idx;
					chg_q <= 1'b1;
					inv_q <= !suppress_q && binding_q;
				end
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load_out) begin
			ov_q <= 1'b1;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			o_idx_q  <= cur_q;
			o_res_q  <= rdata[sfs_pkg::ENTRY_W-1:sfs_pkg::DUR_W];
			o_chg_q  <= chg_q;
			o_inv_q  <= inv_q;
			o_done_q <= done_q;
			o_pos_q  <= pos_q;
		end
	end

	assign rsp.valid          = ov_q;
	assign rsp.frame_index    = o_idx_q;
	assign rsp.frame_resource = o_res_q;
	assign rsp.frame_changed  = o_chg_q;
	assign rsp.invalidate     = o_inv_q;
	assign rsp.done_res       = o_done_q;
	assign rsp.position       = $signed(o_pos_q);

	`include "sprite_frame_sequencer_core_assert.svh"

	// walk index never reaches the frame count
	`SFS_ASSERT_NOW(a_walk_bound, state_q == S_WALK, i_q < count_q, "walk index out of range")
	// invalidate only ever comes with a frame change
	`SFS_ASSERT_NOW(a_inv_chg, rsp.valid && rsp.invalidate, rsp.frame_changed, "invalidate without change")
	// loading the response returns the sequencer to idle with a valid response
	`SFS_ASSERT_NEXT(a_out_idle, load_out, (state_q == S_IDLE) && rsp.valid, "response load lost")

endmodule

>>> test/tb_sprite_frame_sequencer_core.sv
// Testbench for sprite_frame_sequencer_core: directed and random traffic on the
// request channel, every response checked against an in-bench sequencer model.
// Depends on sfs_pkg, sfs_channels (sfs_req_if, sfs_rsp_if) and the core RTL.
`timescale 1ns / 1ps

module tb_sprite_frame_sequencer_core;

	localparam logic [1:0] FN_UNUSED = 2'd3;	// decoded by nobody, must be a no-op

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 8;
	localparam int SETTLE_CYCLES  = 4;
	// drain after the last response: room for one more full 255-frame walk
	localparam int DRAIN_CYCLES   = 270;
	// longest legal gap between two transfers is one full walk plus a receiver
	// stall tail, or the drain above; this is several times that
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_LIMIT   = 10;
	// ticks of steady growth past the 24-bit restart range
	localparam int GROWTH_TICKS   = 50;
	localparam int RANDOM_ITEMS   = 250;	// per pacing phase

	typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

	typedef struct packed {
		logic [1:0]  func;
		logic        hold;
		logic [7:0]  entry_index;
		logic [15:0] entry_duration;
		logic [15:0] entry_resource;
		logic [23:0] start_position;
	} seq_cmd_t;

	typedef struct packed {
		logic [7:0]  frame_index;
		logic [15:0] frame_resource;
		logic        frame_changed;
		logic        invalidate;
		logic        done_res;
		logic [31:0] position;
	} seq_view_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [sfs_pkg::CFG_DATA_W-1:0] cfg_wdata;

	sfs_req_if req_ch ();
	sfs_rsp_if rsp_ch ();

	sprite_frame_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// ------------------------------------------------------------------
	// Sequencer model state: registers, position/done/frame, frame table.
	// The table is fully written before anything can read it.
	// ------------------------------------------------------------------
	logic [15:0] sq_speed;
	logic        sq_loop;
	logic [7:0]  sq_first;
	logic [7:0]  sq_count;
	logic [15:0] sq_total;
	logic        sq_suppress;
	logic        sq_binding;
	logic [31:0] sq_pos;
	logic        sq_done;
	logic [7:0]  sq_frame;
	logic [15:0] tbl_dur [0:255];
	logic [15:0] tbl_res [0:255];

	seq_view_t expected_views [$];	// one per accepted request, oldest first
	int        mismatches     = 0;
	int        idle_cycles    = 0;
	int        send_gap_pct   = 0;
	int        recv_stall_pct = 0;

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Walk durations from the first frame until the elapsed whole units fall
	// inside a frame. Negative positions stop on the first entry; running off
	// the end returns frame_count.
	function automatic logic [7:0] walk_to_frame(input logic [31:0] pos);
		logic [31:0] acc;
		logic [7:0]  slot;
		int          i;
		bit          found;
		acc   = '0;
		i     = 0;
		found = 1'b0;
		while (!found && i < sq_count) begin
			slot = sq_first + i[7:0];
			acc  = acc + {16'd0, tbl_dur[slot]};
			if (pos[31] || {8'd0, pos[31:8]} < acc)
				found = 1'b1;
			else
				i++;
		end
		return i[7:0];
	endfunction

	// Advance the model by one request and return the response it must give.
	function automatic seq_view_t apply_cmd(input seq_cmd_t c);
		logic [31:0] inc;
		logic [31:0] span;
		logic [31:0] pos;
		logic [7:0]  idx;
		seq_view_t   v;
		v = '0;
		case (c.func)
		sfs_pkg::FN_TICK: begin
			if (!c.hold && !sq_done) begin
				inc  = {{16{sq_speed[15]}}, sq_speed};
				span = {8'd0, sq_total, 8'd0};
				pos  = sq_pos + inc;
				// one wrap only; a big speed can leave pos outside the span
				if (pos[31]) begin
					if (sq_loop)
						pos = pos + span;
					else begin
						sq_done = 1'b1;
						pos     = '0;
					end
				end else if (pos[31:8] >= {8'd0, sq_total}) begin
					if (sq_loop)
						pos = pos - span;
					else begin
						// zero total gives -256 here
						sq_done = 1'b1;
						pos     = ({16'd0, sq_total} - 32'd1) << sfs_pkg::FRAC_BITS;
					end
				end
				sq_pos = pos;
				idx    = walk_to_frame(pos);
				if (idx != sq_frame) begin
					sq_frame        = idx;
					v.frame_changed = 1'b1;
					v.invalidate    = !sq_suppress && sq_binding;
				end
			end
		end
		sfs_pkg::FN_WRITE: begin
			tbl_dur[c.entry_index] = c.entry_duration;
			tbl_res[c.entry_index] = c.entry_resource;
		end
		sfs_pkg::FN_RESTART: begin
			// frame index is left alone until the next tick
			sq_pos  = {8'd0, c.start_position};
			sq_done = 1'b0;
		end
		default: ;
		endcase
		v.frame_index    = sq_frame;
		v.frame_resource = tbl_res[8'(sq_first + sq_frame)];
		v.done_res       = sq_done;
		v.position       = sq_pos;
		return v;
	endfunction

	// Whole-unit length of a sequence as the table holds it now.
	function automatic int unsigned sequence_units(input logic [7:0] first, input logic [7:0] count);
		int unsigned sum;
		logic [7:0]  slot;
		sum = 0;
		for (int i = 0; i < count; i++) begin
			slot = first + i[7:0];
			sum  = sum + tbl_dur[slot];
		end
		return sum;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			if (mismatches < REPORT_LIMIT)
				$display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor: checks each response transfer against the oldest prediction,
	// then predicts for a request transfer on the same edge. Both channels are
	// sampled at the rising edge; the bench drives on the falling edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		seq_view_t want;
		seq_cmd_t  cmd;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (expected_views.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("%0t: response transfer with nothing outstanding", $realtime);
				mismatches++;
			end else begin
				want = expected_views.pop_front();
				check_field("frame_index", want.frame_index, rsp_ch.frame_index);
				check_field("frame_resource", want.frame_resource, rsp_ch.frame_resource);
				check_field("frame_changed", want.frame_changed, rsp_ch.frame_changed);
				check_field("invalidate", want.invalidate, rsp_ch.invalidate);
				check_field("done_res", want.done_res, rsp_ch.done_res);
				check_field("position", want.position, rsp_ch.position);
			end
		end
		if (req_ch.valid && req_ch.ready) begin
			cmd.func           = req_ch.func;
			cmd.hold           = req_ch.hold;
			cmd.entry_index    = req_ch.entry_index;
			cmd.entry_duration = req_ch.entry_duration;
			cmd.entry_resource = req_ch.entry_resource;
			cmd.start_position = req_ch.start_position;
			expected_views.push_back(apply_cmd(cmd));
		end
	end

	// Watchdog: cycles without any transfer on either channel.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[sprite_frame_sequencer_core] ERROR");
			$finish;
		end
	end

	// Receiver: ready drops at random per the current pacing.
	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	task automatic set_pace(input pace_t pace);
		case (pace)
		PACE_FULL: begin
			send_gap_pct   = 0;
			recv_stall_pct = 0;
		end
		PACE_SEND_IDLE: begin
			send_gap_pct   = 78;
			recv_stall_pct = 0;
		end
		PACE_RECV_STALL: begin
			send_gap_pct   = 0;
			recv_stall_pct = 78;
		end
		default: begin
			send_gap_pct   = 8;
			recv_stall_pct = 8;
		end
		endcase
	endtask

	// One request transfer. Valid stays high after the transfer until the
	// next falling edge, where the next call either reloads it or idles.
	task automatic send_cmd(input seq_cmd_t c);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid          = 1'b1;
		req_ch.func           = c.func;
		req_ch.hold           = c.hold;
		req_ch.entry_index    = c.entry_index;
		req_ch.entry_duration = c.entry_duration;
		req_ch.entry_resource = c.entry_resource;
		req_ch.start_position = c.start_position;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// Random filler for the fields the function code does not use.
	function automatic seq_cmd_t noise_cmd();
		seq_cmd_t c;
		c.func           = sfs_pkg::FN_TICK;
		c.hold           = 1'($urandom_range(0, 1));
		c.entry_index    = 8'($urandom_range(0, 255));
		c.entry_duration = 16'($urandom_range(0, 65535));
		c.entry_resource = 16'($urandom_range(0, 65535));
		c.start_position = 24'($urandom_range(0, 24'hFFFFFF));
		return c;
	endfunction

	task automatic do_tick(input logic held);
		seq_cmd_t c;
		c      = noise_cmd();
		c.hold = held;
		send_cmd(c);
	endtask

	task automatic do_write(input logic [7:0] idx, input logic [15:0] dur, input logic [15:0] res);
		seq_cmd_t c;
		c                = noise_cmd();
		c.func           = sfs_pkg::FN_WRITE;
		c.entry_index    = idx;
		c.entry_duration = dur;
		c.entry_resource = res;
		send_cmd(c);
	endtask

	task automatic do_restart(input logic [23:0] pos);
		seq_cmd_t c;
		c                = noise_cmd();
		c.func           = sfs_pkg::FN_RESTART;
		c.start_position = pos;
		send_cmd(c);
	endtask

	task automatic do_unused();
		seq_cmd_t c;
		c      = noise_cmd();
		c.func = FN_UNUSED;
		send_cmd(c);
	endtask

	// Stop sending and wait for every outstanding response.
	task automatic wait_results();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (expected_views.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sfs_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
	endtask

	// Full register set, written only with the core drained.
	task automatic configure(input logic [15:0] spd, input logic lp, input logic [7:0] first,
		input logic [7:0] count, input logic [15:0] total, input logic supp, input logic binding);
		wait_results();
		write_reg(sfs_pkg::REG_SPEED, spd);
		write_reg(sfs_pkg::REG_LOOP, {15'd0, lp});
		write_reg(sfs_pkg::REG_FIRST, {8'd0, first});
		write_reg(sfs_pkg::REG_COUNT, {8'd0, count});
		write_reg(sfs_pkg::REG_TOTAL, total);
		write_reg(sfs_pkg::REG_SUPPRESS, {15'd0, supp});
		write_reg(sfs_pkg::REG_BINDING, {15'd0, binding});
		@(negedge clk);
		cfg_we      = 1'b0;
		sq_speed    = spd;
		sq_loop     = lp;
		sq_first    = first;
		sq_count    = count;
		sq_total    = total;
		sq_suppress = supp;
		sq_binding  = binding;
	endtask

	// Every table entry gets written before any read; entry 0 first since the
	// very first response already reports entry first_frame + 0.
	task automatic test_table_fill();
		logic [15:0] dur;
		logic [15:0] res;
		for (int i = 0; i < 256; i++) begin
			dur = 16'($urandom_range(1, 6));
			res = 16'($urandom_range(0, 65535));
			if (i % 41 == 9)
				dur = 16'd0;	// zero-length frames sprinkled through the table
			if (i == 128) begin
				dur = 16'hFFFF;
				res = 16'hFFFF;
			end
			if (i == 127)
				res = 16'h0000;
			do_write(8'(i), dur, res);
		end
	endtask

	// Clamp at both ends, done latch, held tick, unused code, restart.
	task automatic test_clamp_and_done();
		int unsigned units;
		// sequence wraps the table end and holds a zero-length frame
		units = sequence_units(8'd250, 8'd10);
		configure(16'd768, 1'b0, 8'd250, 8'd10, 16'(units), 1'b0, 1'b1);
		do_restart(24'd0);
		do_tick(1'b0);
		do_tick(1'b0);
		do_tick(1'b1);
		do_unused();
		do_tick(1'b0);
		do_restart(24'((units - 1) * 256));
		do_tick(1'b0);	// past the end: clamp, done
		do_tick(1'b0);	// done: no motion
		do_restart(24'd0);
		configure(16'h8000, 1'b0, 8'd250, 8'd10, 16'(units), 1'b0, 1'b1);
		do_tick(1'b0);	// below zero: clamp to 0, done
		do_tick(1'b0);
		configure(16'd0, 1'b0, 8'd255, 8'd2, 16'hFFFF, 1'b0, 1'b1);
		do_restart(24'hFFFFFF);
		do_tick(1'b0);
	endtask

	// Loop wrap at both ends, oversize speed, long walks, invalidate gating.
	task automatic test_loop_wrap();
		int unsigned units;
		configure(16'h7FFF, 1'b1, 8'd0, 8'd255, 16'd2, 1'b0, 1'b1);
		do_restart(24'd0);
		do_tick(1'b0);
		do_tick(1'b0);
		do_tick(1'b0);
		configure(16'h8000, 1'b1, 8'd0, 8'd255, 16'd2, 1'b1, 1'b1);
		do_restart(24'd256);
		do_tick(1'b0);
		do_tick(1'b0);
		units = sequence_units(8'd120, 8'd12);
		configure(16'hFED4, 1'b1, 8'd120, 8'd12, (units > 65535) ? 16'hFFFF : 16'(units),
			1'b0, 1'b0);
		do_restart(24'd0);
		do_tick(1'b0);
		do_tick(1'b0);
	endtask

	// Zero total duration, with and without looping; empty sequence.
	task automatic test_zero_total();
		configure(16'd256, 1'b0, 8'd5, 8'd0, 16'd0, 1'b0, 1'b1);
		do_restart(24'd0);
		do_tick(1'b0);	// clamps to -256
		do_tick(1'b0);
		do_restart(24'd100);
		configure(16'd256, 1'b1, 8'd5, 8'd3, 16'd0, 1'b0, 1'b1);
		do_tick(1'b0);
		do_tick(1'b0);
	endtask

	// Position keeps growing with a zero span: the loop wrap subtracts nothing.
	task automatic test_position_growth();
		configure(16'h7FFF, 1'b1, 8'd0, 8'd0, 16'd0, 1'b0, 1'b1);
		do_restart(24'hFFFFFF);
		repeat (GROWTH_TICKS) do_tick(1'b0);
	endtask

	// Random sequences: mostly short, a few full 255-frame walks; each scenario
	// is a fresh register set, a restart and a burst of mixed requests.
	task automatic test_random_traffic(input pace_t pace, input int target);
		int          sent;
		int          pick;
		int          sv;
		int unsigned units;
		int unsigned lim;
		logic [7:0]  first;
		logic [7:0]  count;
		logic [7:0]  slot;
		logic [15:0] total;
		logic [15:0] dur;
		set_pace(pace);
		sent = 0;
		while (sent < target) begin
			first = 8'($urandom_range(0, 255));
			pick  = $urandom_range(0, 99);
			count = (pick < 4) ? 8'd255 : (pick < 10) ? 8'd0 : 8'($urandom_range(1, 16));
			units = sequence_units(first, count);
			pick  = $urandom_range(0, 99);
			if (pick < 70)
				total = (units > 65535) ? 16'hFFFF : 16'(units);
			else if (pick < 80)
				total = 16'd0;
			else
				total = 16'($urandom_range(0, 65535));
			pick = $urandom_range(0, 99);
			if (pick < 70)
				sv = $urandom_range(0, 1400) - 500;
			else if (pick < 90)
				sv = $urandom_range(0, 65535);
			else if (pick < 95)
				sv = 32767;
			else
				sv = -32768;
			configure(16'(sv), 1'($urandom_range(0, 1)), first, count, total,
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			lim = {8'd0, total, 8'd0};
			if (lim != 0 && $urandom_range(0, 9) != 0)
				do_restart(24'($urandom_range(0, lim - 1)));
			else
				do_restart(24'($urandom_range(0, 24'hFFFFFF)));
			sent++;
			repeat ($urandom_range(15, 40)) begin
				pick = $urandom_range(0, 99);
				if (pick < 62)
					do_tick(1'b0);
				else if (pick < 70)
					do_tick(1'b1);
				else if (pick < 82) begin
					if (count != 0 && $urandom_range(0, 1))
						slot = first + 8'($urandom_range(0, count - 1));
					else
						slot = 8'($urandom_range(0, 255));
					if ($urandom_range(0, 99) < 85)
						dur = 16'($urandom_range(0, 8));
					else
						dur = 16'($urandom_range(0, 65535));
					do_write(slot, dur, 16'($urandom_range(0, 65535)));
				end else if (pick < 94) begin
					if (lim != 0)
						do_restart(24'($urandom_range(0, lim - 1)));
					else
						do_restart(24'($urandom_range(0, 24'hFFFFFF)));
				end else
					do_unused();
				if (pick < 94)
					sent++;
				// occasionally hold off until the core has answered everything
				if ($urandom_range(0, 39) == 0)
					wait_results();
			end
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = '0;
		cfg_wdata             = '0;
		req_ch.valid          = 1'b0;
		req_ch.func           = sfs_pkg::FN_TICK;
		req_ch.hold           = 1'b0;
		req_ch.entry_index    = '0;
		req_ch.entry_duration = '0;
		req_ch.entry_resource = '0;
		req_ch.start_position = '0;
		rsp_ch.ready          = 1'b0;
		// model reset values
		sq_speed    = sfs_pkg::SPEED_RST;
		sq_loop     = 1'b0;
		sq_first    = '0;
		sq_count    = '0;
		sq_total    = '0;
		sq_suppress = 1'b0;
		sq_binding  = 1'b0;
		sq_pos      = '0;
		sq_done     = 1'b0;
		sq_frame    = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_pace(PACE_FULL);
		test_table_fill();
		test_clamp_and_done();
		test_loop_wrap();
		test_zero_total();
		test_position_growth();
		test_random_traffic(PACE_FULL, RANDOM_ITEMS);
		test_random_traffic(PACE_SEND_IDLE, RANDOM_ITEMS);
		test_random_traffic(PACE_RECV_STALL, RANDOM_ITEMS);
		test_random_traffic(PACE_BOTH, RANDOM_ITEMS);

		wait_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_views.size() == 0)
			$display("[sprite_frame_sequencer_core] OK");
		else
			$display("[sprite_frame_sequencer_core] ERROR");
		$finish;
	end

endmodule

>>> sprite_frame_sequencer_core.f
+incdir+rtl
rtl/sfs_pkg.sv
rtl/sfs_channels.sv
rtl/sfs_ram.sv
rtl/sprite_frame_sequencer_core.sv
test/tb_sprite_frame_sequencer_core.sv
